/* design/g2j_pkg.sv */
package g2j_pkg;

  // field widths
  localparam int unsigned GY_W = 12;
  localparam int unsigned GM_W = 4;
  localparam int unsigned GD_W = 5;
  localparam int unsigned JY_W = 12;
  localparam int unsigned JM_W = 4;
  localparam int unsigned JD_W = 5;

  // accepted gregorian range
  localparam logic [GY_W-1:0] YEAR_MIN  = 12'd1601;
  localparam logic [GY_W-1:0] YEAR_MAX  = 12'd3199;
  localparam logic [GY_W-1:0] YEAR_BASE = 12'd1600;
  localparam logic [GM_W-1:0] MONTH_MAX = 4'd12;

  // day count arithmetic
  localparam logic [19:0] DAYS_PER_YEAR = 20'd365;
  localparam logic [19:0] EPOCH_SHIFT   = 20'd80;   // 79 day offset plus the day - 1 term

  // 33 year cycle, reciprocal estimate is low by at most one
  localparam logic [19:0] CYCLE_DAYS  = 20'd12053;
  localparam logic [30:0] CYCLE_RECIP = 31'd1391;
  localparam int unsigned CYCLE_SHIFT = 24;
  localparam logic [JY_W-1:0] CYCLE_YEARS = 12'd33;

  // 4 year group
  localparam logic [13:0] GROUP_DAYS  = 14'd1461;
  localparam logic [19:0] GROUP_RECIP = 20'd44;
  localparam int unsigned GROUP_SHIFT = 16;

  localparam logic [JY_W-1:0] JAL_EPOCH_YEAR = 12'd979;

  // cumulative month starts, days before the first of each month
  localparam logic [8:0] GREG_CUM [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                           9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
  localparam logic [8:0] JAL_CUM [12]  = '{9'd0, 9'd31, 9'd62, 9'd93, 9'd124, 9'd155,
                                           9'd186, 9'd216, 9'd246, 9'd276, 9'd306, 9'd336};

endpackage

/* design/g2j_in_if.sv */
interface g2j_in_if;
  logic                        valid;
  logic                        ready;
  logic [g2j_pkg::GY_W-1:0]    greg_year;
  logic [g2j_pkg::GM_W-1:0]    greg_month;
  logic [g2j_pkg::GD_W-1:0]    greg_day;

  modport source (output valid, greg_year, greg_month, greg_day, input ready);
  modport sink   (input valid, greg_year, greg_month, greg_day, output ready);
endinterface

/* design/g2j_out_if.sv */
interface g2j_out_if;
  logic                        valid;
  logic                        ready;
  logic [g2j_pkg::JY_W-1:0]    jal_year;
  logic [g2j_pkg::JM_W-1:0]    jal_month;
  logic [g2j_pkg::JD_W-1:0]    jal_day;

  modport source (output valid, jal_year, jal_month, jal_day, input ready);
  modport sink   (input valid, jal_year, jal_month, jal_day, output ready);
endinterface

/* design/gregorian_to_jalali_date.sv */
// gregorian to jalali date conversion, eleven stage pipeline
//
// in_date carries one gregorian date per transfer (year, month, day); out_date
// returns the matching jalali date, one result per input, in order.
// year is saturated to 1601..3199 and month to 1..12; the day is not checked
// against the month length and is simply added as an offset (day zero gives
// the day before the first).
// throughput: one date per cycle while the output register is free or being
// taken; every stage is a register with a valid bit.
// the stage split is set by the constant divisions: day count, 33 year cycle
// (reciprocal estimate, remainder, correction), 4 year group (same three
// steps), year within group, then month and day.
// stall: when out_date.ready is low with a result waiting, the whole pipe
// freezes and in_date.ready drops in the same cycle; nothing is lost or
// repeated. with the output free or taken, a new date is accepted every cycle.
// reset: rst_n (synchronous, active low) clears all valid bits; there is no
// other state, so the block is ready as soon as reset is released.
module gregorian_to_jalali_date (
  input  logic             clk,
  input  logic             rst_n,
  g2j_in_if.sink           in_date,
  g2j_out_if.source        out_date
);

  localparam int unsigned NS = 11;

  logic [NS-1:0] v_r;
  logic          en;

  // pipe moves whenever the output register is empty or being taken
  assign en            = !v_r[NS-1] || out_date.ready;
  assign in_date.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_date.valid};
    end
  end

  // stage 1: clamp, year offset, leap correction terms
  logic [11:0] yc;
  logic [3:0]  mc;
  logic [23:0] p100, p400;
  logic [10:0] s1_gy_nxt, s1_gy_r;
  logic [3:0]  s1_gm_nxt, s1_gm_r;
  logic [4:0]  s1_d_r;
  logic [8:0]  s1_c4_nxt, s1_c4_r;
  logic [4:0]  s1_c100_nxt, s1_c100_r;
  logic [2:0]  s1_c400_nxt, s1_c400_r;

  always_comb begin
    yc = in_date.greg_year;
    if (yc < g2j_pkg::YEAR_MIN) yc = g2j_pkg::YEAR_MIN;
    if (yc > g2j_pkg::YEAR_MAX) yc = g2j_pkg::YEAR_MAX;
    mc = in_date.greg_month;
    if (mc == 4'd0) mc = 4'd1;
    if (mc > g2j_pkg::MONTH_MAX) mc = g2j_pkg::MONTH_MAX;
    s1_gy_nxt   = 11'(yc - g2j_pkg::YEAR_BASE);
    s1_gm_nxt   = mc - 4'd1;
    s1_c4_nxt   = 9'((12'(s1_gy_nxt) + 12'd3) >> 2);
    // ceil(gy/100) and ceil(gy/400) by reciprocal, exact below 4681
    p100        = (24'(s1_gy_nxt) + 24'd99) * 24'd1311;
    p400        = (24'(s1_gy_nxt) + 24'd399) * 24'd1311;
    s1_c100_nxt = 5'(p100 >> 17);
    s1_c400_nxt = 3'(p400 >> 19);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_gy_r   <= s1_gy_nxt;
      s1_gm_r   <= s1_gm_nxt;
      s1_d_r    <= in_date.greg_day;
      s1_c4_r   <= s1_c4_nxt;
      s1_c100_r <= s1_c100_nxt;
      s1_c400_r <= s1_c400_nxt;
    end
  end

  // stage 2: whole years in days, plus offset inside the year
  logic        leap;
  logic [19:0] s2_base_nxt, s2_base_r;
  logic [8:0]  s2_off_nxt, s2_off_r;

  always_comb begin
    // ceil equals the exact quotient only on multiples
    leap = ((s1_gy_r[1:0] == 2'b00) && ((11'(s1_c100_r) * 11'd100) != s1_gy_r)) ||
           ((11'(s1_c400_r) * 11'd400) == s1_gy_r);
    s2_base_nxt = 20'(s1_gy_r) * g2j_pkg::DAYS_PER_YEAR + 20'(s1_c4_r)
                  - 20'(s1_c100_r) + 20'(s1_c400_r);
    s2_off_nxt  = g2j_pkg::GREG_CUM[s1_gm_r] + 9'(leap && (s1_gm_r > 4'd1))
                  + 9'(s1_d_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_base_r <= s2_base_nxt;
      s2_off_r  <= s2_off_nxt;
    end
  end

  // stage 3: day count from the jalali epoch
  logic [19:0] s3_days_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_days_r <= s2_base_r + 20'(s2_off_r) - g2j_pkg::EPOCH_SHIFT;
    end
  end

  // stage 4: 33 year cycle estimate
  logic [30:0] cyc_prod;
  logic [19:0] s4_x_r;
  logic [5:0]  s4_qe_r;

  assign cyc_prod = 31'(s3_days_r) * g2j_pkg::CYCLE_RECIP;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x_r  <= s3_days_r;
      s4_qe_r <= 6'(cyc_prod >> g2j_pkg::CYCLE_SHIFT);
    end
  end

  // stage 5: remainder against the estimate
  logic [14:0] s5_r_r;
  logic [5:0]  s5_qe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r_r  <= 15'(s4_x_r - 20'(s4_qe_r) * g2j_pkg::CYCLE_DAYS);
      s5_qe_r <= s4_qe_r;
    end
  end

  // stage 6: correct a low estimate
  logic        cyc_fix;
  logic [5:0]  s6_q_r;
  logic [13:0] s6_r_r;

  assign cyc_fix = s5_r_r >= 15'(g2j_pkg::CYCLE_DAYS);

  always_ff @(posedge clk) begin
    if (en) begin
      s6_q_r <= s5_qe_r + 6'(cyc_fix);
      s6_r_r <= cyc_fix ? 14'(s5_r_r - 15'(g2j_pkg::CYCLE_DAYS)) : 14'(s5_r_r);
    end
  end

  // stage 7: cycle years, 4 year group estimate
  logic [19:0] grp_prod;
  logic [11:0] s7_yb_r;
  logic [13:0] s7_r_r;
  logic [3:0]  s7_g_r;

  assign grp_prod = 20'(s6_r_r) * g2j_pkg::GROUP_RECIP;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_yb_r <= g2j_pkg::JAL_EPOCH_YEAR + 12'(s6_q_r) * g2j_pkg::CYCLE_YEARS;
      s7_r_r  <= s6_r_r;
      s7_g_r  <= 4'(grp_prod >> g2j_pkg::GROUP_SHIFT);
    end
  end

  // stage 8: group remainder
  logic [11:0] s8_r_r;
  logic [11:0] s8_yb_r;
  logic [3:0]  s8_g_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_r_r  <= 12'(s7_r_r - 14'(s7_g_r) * g2j_pkg::GROUP_DAYS);
      s8_yb_r <= s7_yb_r;
      s8_g_r  <= s7_g_r;
    end
  end

  // stage 9: correct group estimate, add group years
  logic        grp_fix;
  logic [3:0]  grp_q;
  logic [10:0] s9_r2_r;
  logic [11:0] s9_yg_r;

  assign grp_fix = s8_r_r >= 12'(g2j_pkg::GROUP_DAYS);
  assign grp_q   = s8_g_r + 4'(grp_fix);

  always_ff @(posedge clk) begin
    if (en) begin
      s9_r2_r <= grp_fix ? 11'(s8_r_r - 12'(g2j_pkg::GROUP_DAYS)) : 11'(s8_r_r);
      s9_yg_r <= s8_yb_r + (12'(grp_q) << 2);
    end
  end

  // stage 10: year inside the group, first year is the long one
  logic [10:0] t;
  logic [1:0]  yi;
  logic [8:0]  s10_rem_nxt, s10_rem_r;
  logic [11:0] s10_y_r;

  always_comb begin
    t  = s9_r2_r - 11'd1;
    yi = 2'd0;
    s10_rem_nxt = 9'(s9_r2_r);
    if (s9_r2_r >= 11'd366) begin
      if (t >= 11'd1095) begin
        yi = 2'd3;
        s10_rem_nxt = 9'(t - 11'd1095);
      end else if (t >= 11'd730) begin
        yi = 2'd2;
        s10_rem_nxt = 9'(t - 11'd730);
      end else if (t >= 11'd365) begin
        yi = 2'd1;
        s10_rem_nxt = 9'(t - 11'd365);
      end else begin
        s10_rem_nxt = 9'(t);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_rem_r <= s10_rem_nxt;
      s10_y_r   <= s9_yg_r + 12'(yi);
    end
  end

  // stage 11: month and day, output register
  logic [3:0]  midx;
  logic [11:0] s11_year_r;
  logic [3:0]  s11_month_r;
  logic [4:0]  s11_day_r;

  always_comb begin
    midx = 4'd0;
    for (int i = 1; i < 12; i++) begin
      midx = midx + 4'(s10_rem_r >= g2j_pkg::JAL_CUM[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s11_year_r  <= s10_y_r;
      s11_month_r <= midx + 4'd1;
      s11_day_r   <= 5'(s10_rem_r - g2j_pkg::JAL_CUM[midx] + 9'd1);
    end
  end

  assign out_date.valid     = v_r[NS-1];
  assign out_date.jal_year  = s11_year_r;
  assign out_date.jal_month = s11_month_r;
  assign out_date.jal_day   = s11_day_r;

  // frozen pipe keeps its occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline occupancy changed during stall");

  a_cycle_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[5] |-> (s6_r_r < 14'(g2j_pkg::CYCLE_DAYS)))
    else $error("33 year remainder out of range");

  a_group_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[8] |-> (s9_r2_r < 11'(g2j_pkg::GROUP_DAYS)))
    else $error("4 year remainder out of range");

  a_month_day: assert property (@(posedge clk) disable iff (!rst_n)
    out_date.valid |-> (s11_month_r >= 4'd1 && s11_month_r <= 4'd12 &&
                        s11_day_r >= 5'd1))
    else $error("jalali month or day out of range");

endmodule

/* tb/gregorian_to_jalali_date_tb.sv */
`timescale 1ns / 100ps

module gregorian_to_jalali_date_tb;

  localparam int unsigned HALF_PERIOD = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned RANDOM_DATES = 800;
  // far beyond the slowest correct run: every date waiting out the longest gap on
  // both sides plus the pipe depth
  localparam longint unsigned RUN_LIMIT_NS = 64'd20_000_000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned MAX_REPORTS = 10;

  // month lengths, february of a common year
  localparam int unsigned GREG_MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  // farvardin first, esfand of a common year last
  localparam int unsigned JAL_MONTH_LEN [12] = '{31, 31, 31, 31, 31, 31, 30, 30, 30, 30, 30, 29};

  typedef struct packed {
    logic [g2j_pkg::JY_W-1:0] year;
    logic [g2j_pkg::JM_W-1:0] month;
    logic [g2j_pkg::JD_W-1:0] day;
  } jal_date_t;

  // ---------------------------------------------------------------------------
  // calendar scoreboard: converts each accepted gregorian date and holds the
  // jalali dates still owed by the block, oldest first
  // ---------------------------------------------------------------------------
  class calendar_book;
    jal_date_t   due_dates[$];
    int unsigned dates_checked;
    int unsigned odd_dates;
    int unsigned mismatches;

    function jal_date_t convert(logic [g2j_pkg::GY_W-1:0] gy_in,
                                logic [g2j_pkg::GM_W-1:0] gm_in,
                                logic [g2j_pkg::GD_W-1:0] gd_in);
      int unsigned year, month, offs, mon_idx, days, cycles, jy, i, jm, jd;
      bit          leap;
      jal_date_t   res;
      // saturate year and month to the accepted range
      year = gy_in;
      if (gy_in < g2j_pkg::YEAR_MIN) year = g2j_pkg::YEAR_MIN;
      if (gy_in > g2j_pkg::YEAR_MAX) year = g2j_pkg::YEAR_MAX;
      month = gm_in;
      if (gm_in == 0) month = 1;
      if (gm_in > g2j_pkg::MONTH_MAX) month = g2j_pkg::MONTH_MAX;
      offs = year - g2j_pkg::YEAR_BASE;
      mon_idx = month - 1;
      // days from 1 jan 1600 to 1 jan of the year, gregorian leap rules
      days = 365 * offs + (offs + 3) / 4 - (offs + 99) / 100 + (offs + 399) / 400;
      for (i = 0; i < mon_idx; i++) days += GREG_MONTH_LEN[i];
      leap = ((offs % 4 == 0) && (offs % 100 != 0)) || (offs % 400 == 0);
      if (mon_idx > 1 && leap) days += 1;
      // day is a plain offset, day zero steps back one
      days = days + gd_in - 1;
      days -= 79;
      // 33 year cycles, then 4 year groups, then single years
      cycles = days / 12053;
      days = days % 12053;
      jy = 979 + 33 * cycles + 4 * (days / 1461);
      days = days % 1461;
      if (days >= 366) begin
        jy += (days - 1) / 365;
        days = (days - 1) % 365;
      end
      // month walk, esfand takes whatever is left
      i = 0;
      while (i < 11 && days >= JAL_MONTH_LEN[i]) begin
        days -= JAL_MONTH_LEN[i];
        i++;
      end
      jm = i + 1;
      jd = days + 1;
      res.year = jy[g2j_pkg::JY_W-1:0];
      res.month = jm[g2j_pkg::JM_W-1:0];
      res.day = jd[g2j_pkg::JD_W-1:0];
      return res;
    endfunction

    function void note_date(logic [g2j_pkg::GY_W-1:0] gy_in,
                            logic [g2j_pkg::GM_W-1:0] gm_in,
                            logic [g2j_pkg::GD_W-1:0] gd_in);
      due_dates.push_back(convert(gy_in, gm_in, gd_in));
      if (gy_in < g2j_pkg::YEAR_MIN || gy_in > g2j_pkg::YEAR_MAX || gm_in == 0 ||
          gm_in > g2j_pkg::MONTH_MAX || gd_in == 0)
        odd_dates++;
    endfunction

    function void check_date(jal_date_t got);
      jal_date_t want;
      if (due_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result %0d/%0d/%0d", $time, got.year, got.month,
                   got.day);
        return;
      end
      want = due_dates.pop_front();
      dates_checked++;
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d", $time,
                   dates_checked, want.year, want.month, want.day, got.year, got.month,
                   got.day);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   no_idle;   // set for stretches where neither side idles

  g2j_in_if  in_date ();
  g2j_out_if out_date ();

  calendar_book book = new();

  gregorian_to_jalali_date dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_date  (in_date),
    .out_date (out_date)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one input transfer, after an optional idle gap with valid low
  task automatic send_date(logic [g2j_pkg::GY_W-1:0] gy, logic [g2j_pkg::GM_W-1:0] gm,
                           logic [g2j_pkg::GD_W-1:0] gd);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_date.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_date.valid <= 1'b1;
    in_date.greg_year <= gy;
    in_date.greg_month <= gm;
    in_date.greg_day <= gd;
    @(posedge clk);
    while (!in_date.ready) @(posedge clk);
    book.note_date(gy, gm, gd);
  endtask

  // random date, mostly in range with the day fitting the month, biased towards
  // nowruz and year ends; some with fields outside their range, some pure noise
  task automatic send_random_date();
    int unsigned r, gy, gm, gd;
    r = $urandom_range(0, 99);
    gy = $urandom_range(g2j_pkg::YEAR_MIN, g2j_pkg::YEAR_MAX);
    gm = $urandom_range(1, 12);
    gd = $urandom_range(1, GREG_MONTH_LEN[gm-1]);
    if (r < 10) begin
      gy = $urandom_range(0, (1 << g2j_pkg::GY_W) - 1);
      gm = $urandom_range(0, (1 << g2j_pkg::GM_W) - 1);
      gd = $urandom_range(0, (1 << g2j_pkg::GD_W) - 1);
    end else if (r < 14) begin
      gy = ($urandom_range(0, 1) != 0) ?
           $urandom_range(0, g2j_pkg::YEAR_MIN - 1) :
           $urandom_range(g2j_pkg::YEAR_MAX + 1, (1 << g2j_pkg::GY_W) - 1);
    end else if (r < 18) begin
      gm = ($urandom_range(0, 1) != 0) ? 0 :
           $urandom_range(g2j_pkg::MONTH_MAX + 1, (1 << g2j_pkg::GM_W) - 1);
    end else if (r < 22) begin
      gd = 0;
    end else if (r < 32) begin
      gd = $urandom_range(1, 31);
    end else if (r < 50) begin
      // around the jalali new year
      gm = 3;
      gd = $urandom_range(17, 24);
    end else if (r < 58) begin
      // century years exercise the gregorian leap exceptions
      gy = 100 * $urandom_range(17, 31) + $urandom_range(0, 1);
      gm = $urandom_range(2, 3);
      gd = $urandom_range(1, 31);
    end else if (r < 66) begin
      gm = 12;
      gd = $urandom_range(28, 31);
    end
    send_date(gy[g2j_pkg::GY_W-1:0], gm[g2j_pkg::GM_W-1:0], gd[g2j_pkg::GD_W-1:0]);
  endtask

  // result side: ready held low for random stretches
  initial begin
    int unsigned hold;
    hold = 0;
    out_date.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_date.ready <= 1'b0;
        hold--;
      end else begin
        out_date.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // every accepted result goes against the oldest pending conversion
  always @(posedge clk) begin
    if (rst_n && out_date.valid && out_date.ready)
      book.check_date({out_date.jal_year, out_date.jal_month, out_date.jal_day});
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", book.due_dates.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned i;
    in_date.valid = 1'b0;
    in_date.greg_year = '0;
    in_date.greg_month = '0;
    in_date.greg_day = '0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: range ends, saturation, day zero and overflowing days, leap rules,
    // nowruz and all-zero / all-one fields
    send_date(12'd1601, 4'd1, 5'd1);
    send_date(12'd3199, 4'd12, 5'd31);
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd4095, 4'd15, 5'd31);
    send_date(12'd1600, 4'd6, 5'd15);
    send_date(12'd3200, 4'd13, 5'd1);
    send_date(12'd1601, 4'd1, 5'd0);
    send_date(12'd2024, 4'd3, 5'd0);
    send_date(12'd2000, 4'd2, 5'd29);
    send_date(12'd2000, 4'd2, 5'd31);
    send_date(12'd2100, 4'd2, 5'd29);
    send_date(12'd2100, 4'd3, 5'd1);
    send_date(12'd2400, 4'd12, 5'd31);
    send_date(12'd2023, 4'd3, 5'd20);
    send_date(12'd2023, 4'd3, 5'd21);
    send_date(12'd2024, 4'd3, 5'd19);
    send_date(12'd2024, 4'd3, 5'd20);
    send_date(12'd2025, 4'd3, 5'd20);
    send_date(12'd1979, 4'd2, 5'd11);
    send_date(12'd2024, 4'd4, 5'd31);
    send_date(12'd2019, 4'd2, 5'd30);
    send_date(12'd2345, 4'd9, 5'd22);

    // random: a back-to-back stretch in the middle with no idling on either side
    for (i = 0; i < RANDOM_DATES; i++) begin
      no_idle = (i >= 300 && i < 450);
      send_random_date();
    end
    @(negedge clk);
    in_date.valid <= 1'b0;

    while (book.due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d conversions, %0d of them with a field outside its range",
             book.dates_checked, book.odd_dates);
    $display("mismatches %0d, results never delivered %0d", book.mismatches,
             book.due_dates.size());
    if (book.mismatches == 0 && book.due_dates.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
